>>> rtl/core/bfs_pkg.sv
package bfs_pkg;

    // ring geometry and run limits
    localparam int DEPTH_LOG2 = 10;
    localparam int MAX_RUN    = 64;
    localparam int MAX_DELIM  = 4;

    localparam int PTR_W   = DEPTH_LOG2;
    localparam logic [PTR_W-1:0] RING_MASK = {PTR_W{1'b1}};
    localparam int CNT_W   = $clog2(MAX_RUN + 1);
    localparam int MLEN_W  = $clog2(MAX_DELIM + 1);

    // fixed field widths
    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int DELIM_W = 32;
    localparam int DLEN_W  = 3;
    localparam int STS_W   = 2;
    localparam int SLEN_W  = 7;
    localparam int USED_W  = 10;
    localparam int WCNT_W  = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_PEEK  = 3'd2,
        ACT_SCANC = 3'd3,
        ACT_SCANK = 3'd4
    } t_action;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NOSPACE  = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // matcher control from the sequencer
    typedef struct packed {
        logic clr;
        logic step;
    } t_match_ctl;

    // delimiter byte k, zero past the packed field
    function automatic logic [BYTE_W-1:0] delim_byte(input logic [DELIM_W-1:0] packed_d,
                                                     input logic [MLEN_W-1:0] k);
        logic [DELIM_W-1:0] sh;
        sh = packed_d >> (32'(k) * 8);
        return BYTE_W'(sh);
    endfunction

endpackage

>>> rtl/core/bfs_ring_ram.sv
module bfs_ring_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/bfs_match.sv
module bfs_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfs_pkg::t_match_ctl         i_ctl,
    input  logic [bfs_pkg::DELIM_W-1:0] i_delim,
    input  logic [bfs_pkg::DLEN_W-1:0]  i_dlen,
    input  logic [bfs_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_hit
);
    import bfs_pkg::*;

    logic [DELIM_W-1:0] r_delim;
    logic [MLEN_W-1:0]  r_dlen;
    logic [MLEN_W-1:0]  r_mlen;
    logic [MLEN_W-1:0]  n_mlen;
    logic [MLEN_W-1:0]  dsat;
    logic [MLEN_W-1:0]  m_restart;
    logic               eq;

    // zero length means one, long ones clip
    always_comb begin
        if (i_dlen == '0) begin
            dsat = MLEN_W'(1);
        end else if (32'(i_dlen) > MAX_DELIM) begin
            dsat = MLEN_W'(MAX_DELIM);
        end else begin
            dsat = MLEN_W'(i_dlen);
        end
    end

    // on a mismatch, retry the same byte against the first delimiter byte
    always_comb begin
        if (i_byte != delim_byte(r_delim, r_mlen) && r_mlen != '0) begin
            m_restart = '0;
        end else begin
            m_restart = r_mlen;
        end
        eq = (i_byte == delim_byte(r_delim, m_restart));
        n_mlen = eq ? m_restart + MLEN_W'(1) : m_restart;
        o_hit = eq && (32'(n_mlen) >= 32'(r_dlen));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlen <= '0;
        end else if (i_ctl.clr) begin
            r_mlen <= '0;
        end else if (i_ctl.step) begin
            r_mlen <= n_mlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_delim <= i_delim;
            r_dlen  <= dsat;
        end
    end

endmodule

>>> rtl/core/byte_ring_fifo_delimiter_scan.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------------------------
// command   | start in, busy out        | i_action i_data_in i_run_length
//           |                           | i_delimiter_bytes i_delimiter_length
// result    | o_strobe, per beat        | o_data_out o_byte_valid o_status
//           |                           | o_scanned_length o_used_after o_written_total o_last
//
// a command is taken at a clock edge with start high and busy low
// write and unused actions: one result beat, shown the cycle after the command, busy stays low
// read or peek of n bytes: busy while the beats come out, beats come back to back
// scan passing k bytes, all returned: a scan pass then a delivery pass, a lone beat when none
//   can pass; the one read port of the ring is used by both passes, as the scan pass and the
//   delivery pass each read one byte a cycle
// reset is synchronous: pointers and byte count clear, ring contents are not cleared
// the receiver cannot stall; every beat is taken in the cycle it is shown
module byte_ring_fifo_delimiter_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bfs_pkg::ACT_W-1:0]   i_action,
    input  logic [bfs_pkg::BYTE_W-1:0]  i_data_in,
    input  logic [bfs_pkg::RUN_W-1:0]   i_run_length,
    input  logic [bfs_pkg::DELIM_W-1:0] i_delimiter_bytes,
    input  logic [bfs_pkg::DLEN_W-1:0]  i_delimiter_length,
    output logic                        o_strobe,
    output logic [bfs_pkg::BYTE_W-1:0]  o_data_out,
    output logic                        o_byte_valid,
    output logic [bfs_pkg::STS_W-1:0]   o_status,
    output logic [bfs_pkg::SLEN_W-1:0]  o_scanned_length,
    output logic [bfs_pkg::USED_W-1:0]  o_used_after,
    output logic [bfs_pkg::WCNT_W-1:0]  o_written_total,
    output logic                        o_last
);
    import bfs_pkg::*;

    // sequencer state and ring pointers
    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_rp, n_rp;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [WCNT_W-1:0]   r_wcount, n_wcount;

    // run bookkeeping: reads issued, bytes handled, pass limit, bytes to return
    logic [CNT_W-1:0]    r_iss, n_iss;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [CNT_W-1:0]    r_lim, n_lim;
    logic [CNT_W-1:0]    r_nb, n_nb;
    logic                r_consume, n_consume;
    t_status             r_fin_status, n_fin_status;
    logic [PTR_W-1:0]    r_fin_used, n_fin_used;

    // result beat register
    logic                r_o_strobe, n_o_strobe;
    logic [BYTE_W-1:0]   r_o_data, n_o_data;
    logic                r_o_bvalid, n_o_bvalid;
    t_status             r_o_status, n_o_status;
    logic [SLEN_W-1:0]   r_o_slen, n_o_slen;
    logic [USED_W-1:0]   r_o_used, n_o_used;
    logic [WCNT_W-1:0]   r_o_written, n_o_written;
    logic                r_o_last, n_o_last;

    logic                accept;
    logic [PTR_W-1:0]    used;
    logic [CNT_W-1:0]    run_sat;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    cnt_inc;
    logic                issue;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic                wr_en;
    t_match_ctl          mctl;
    logic                m_hit;

    bfs_ring_ram #(
        .AW (PTR_W),
        .DW (BYTE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (i_data_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // shared byte compare unit, stepped once per byte of the scan pass
    bfs_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mctl),
        .i_delim (i_delimiter_bytes),
        .i_dlen  (i_delimiter_length),
        .i_byte  (rd_data),
        .o_hit   (m_hit)
    );

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign used    = r_wp - r_rp;
    assign cnt_inc = r_cnt + CNT_W'(1);

    // run length clipped, then limited to the bytes held
    always_comb begin
        if (32'(i_run_length) > MAX_RUN) begin
            run_sat = CNT_W'(MAX_RUN);
        end else begin
            run_sat = CNT_W'(i_run_length);
        end
        if (32'(used) < 32'(run_sat)) begin
            lim = CNT_W'(used);
        end else begin
            lim = run_sat;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_wcount     = r_wcount;
        n_iss        = r_iss;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_lim        = r_lim;
        n_nb         = r_nb;
        n_consume    = r_consume;
        n_fin_status = r_fin_status;
        n_fin_used   = r_fin_used;
        n_o_strobe   = 1'b0;
        n_o_data     = r_o_data;
        n_o_bvalid   = r_o_bvalid;
        n_o_status   = r_o_status;
        n_o_slen     = r_o_slen;
        n_o_used     = r_o_used;
        n_o_written  = r_o_written;
        n_o_last     = r_o_last;
        issue        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_rp + PTR_W'(r_iss);
        wr_en        = 1'b0;
        mctl         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_iss = '0;
                    n_cnt = '0;
                    case (i_action)
                        ACT_WRITE: begin
                            n_o_strobe = 1'b1;
                            n_o_data   = '0;
                            n_o_bvalid = 1'b0;
                            n_o_slen   = '0;
                            n_o_last   = 1'b1;
                            if (used == RING_MASK) begin
                                // full: byte dropped
                                n_o_status  = STS_NOSPACE;
                                n_o_used    = USED_W'(used);
                                n_o_written = r_wcount;
                            end else begin
                                wr_en       = 1'b1;
                                n_wp        = r_wp + PTR_W'(1);
                                n_wcount    = r_wcount + WCNT_W'(1);
                                n_o_status  = STS_OK;
                                n_o_used    = USED_W'(used + PTR_W'(1));
                                n_o_written = r_wcount + WCNT_W'(1);
                            end
                        end
                        ACT_READ, ACT_PEEK: begin
                            n_nb         = lim;
                            n_consume    = (i_action == ACT_READ);
                            n_fin_status = (used == '0) ? STS_EMPTY : STS_OK;
                            n_fin_used   = (i_action == ACT_READ) ? used - PTR_W'(lim) : used;
                            n_state      = ST_EMIT;
                        end
                        ACT_SCANC, ACT_SCANK: begin
                            mctl.clr  = 1'b1;
                            n_lim     = lim;
                            n_consume = (i_action == ACT_SCANC);
                            if (lim == '0) begin
                                // nothing to pass: lone beat, not found
                                n_nb         = '0;
                                n_consume    = 1'b0;
                                n_fin_status = STS_NOTFOUND;
                                n_fin_used   = used;
                                n_state      = ST_EMIT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused action codes
                            n_o_strobe  = 1'b1;
                            n_o_data    = '0;
                            n_o_bvalid  = 1'b0;
                            n_o_status  = STS_OK;
                            n_o_slen    = '0;
                            n_o_used    = USED_W'(used);
                            n_o_written = r_wcount;
                            n_o_last    = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // read one byte ahead of the compare
                issue  = (r_iss < r_lim);
                rd_en  = issue;
                n_pend = issue;
                if (issue) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_pend) begin
                    mctl.step = 1'b1;
                    n_cnt     = cnt_inc;
                    if (m_hit) begin
                        n_nb         = cnt_inc;
                        n_fin_status = STS_OK;
                        n_fin_used   = r_consume ? used - PTR_W'(cnt_inc) : used;
                        n_state      = ST_EMIT;
                    end else if (cnt_inc == r_lim) begin
                        n_nb         = r_lim;
                        n_consume    = 1'b0;
                        n_fin_status = STS_NOTFOUND;
                        n_fin_used   = used;
                        n_state      = ST_EMIT;
                    end
                    if (m_hit || cnt_inc == r_lim) begin
                        // restart counters for the delivery pass
                        n_iss  = '0;
                        n_cnt  = '0;
                        n_pend = 1'b0;
                    end
                end
            end

            ST_EMIT: begin
                n_o_status  = r_fin_status;
                n_o_slen    = SLEN_W'(r_nb);
                n_o_used    = USED_W'(r_fin_used);
                n_o_written = r_wcount;
                if (r_nb == '0) begin
                    n_o_strobe = 1'b1;
                    n_o_data   = '0;
                    n_o_bvalid = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    issue  = (r_iss < r_nb);
                    rd_en  = issue;
                    n_pend = issue;
                    if (issue) begin
                        n_iss = r_iss + CNT_W'(1);
                    end
                    if (r_pend) begin
                        n_o_strobe = 1'b1;
                        n_o_data   = rd_data;
                        n_o_bvalid = 1'b1;
                        n_o_last   = (cnt_inc == r_nb);
                        n_cnt      = cnt_inc;
                        if (cnt_inc == r_nb) begin
                            n_state = ST_IDLE;
                            n_pend  = 1'b0;
                            if (r_consume) begin
                                n_rp = r_rp + PTR_W'(r_nb);
                            end
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rp       <= '0;
            r_wp       <= '0;
            r_wcount   <= '0;
            r_pend     <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_wcount   <= n_wcount;
            r_pend     <= n_pend;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss        <= n_iss;
        r_cnt        <= n_cnt;
        r_lim        <= n_lim;
        r_nb         <= n_nb;
        r_consume    <= n_consume;
        r_fin_status <= n_fin_status;
        r_fin_used   <= n_fin_used;
        r_o_data     <= n_o_data;
        r_o_bvalid   <= n_o_bvalid;
        r_o_status   <= n_o_status;
        r_o_slen     <= n_o_slen;
        r_o_used     <= n_o_used;
        r_o_written  <= n_o_written;
        r_o_last     <= n_o_last;
    end

    assign o_strobe         = r_o_strobe;
    assign o_data_out       = r_o_data;
    assign o_byte_valid     = r_o_bvalid;
    assign o_status         = r_o_status;
    assign o_scanned_length = r_o_slen;
    assign o_used_after     = r_o_used;
    assign o_written_total  = r_o_written;
    assign o_last           = r_o_last;

endmodule

>>> rtl/core/bfs_checker.sv
module bfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [bfs_pkg::ACT_W-1:0]   i_action,
    input logic                        o_strobe,
    input logic [bfs_pkg::BYTE_W-1:0]  o_data_out,
    input logic                        o_byte_valid,
    input logic [bfs_pkg::STS_W-1:0]   o_status,
    input logic [bfs_pkg::SLEN_W-1:0]  o_scanned_length,
    input logic                        o_last
);
    import bfs_pkg::*;

    // a beat without a byte carries a zero byte
    a_nobyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_byte_valid |-> o_data_out == '0)
        else $error("beat without byte has nonzero data");

    // byte beats only come from ok or not-found runs
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_byte_valid |-> (o_status == STS_OK || o_status == STS_NOTFOUND)
            && o_scanned_length != '0)
        else $error("byte beat with bad status or zero length");

    // a write answers with a single beat in the next cycle
    a_write_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_action == ACT_WRITE |=> o_strobe && o_last && !o_byte_valid)
        else $error("write did not return one beat");

    // beats of one run are back to back
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a run");

endmodule

bind byte_ring_fifo_delimiter_scan bfs_checker u_bfs_checker (.*);
